>>> rtl/psp_pkg.sv
// Shared constants for the parity-state shortest path unit.
// No dependencies; the interfaces and all modules refer to it by scoped names.
package psp_pkg;

  localparam int unsigned NODE_W   = 10;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned DIST_W   = 48;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_SAT = {{(DIST_W-1){1'b1}}, 1'b0};

endpackage

>>> rtl/psp_if.sv
// Valid/ready channel interfaces of the parity-state shortest path unit.
// Depends on psp_pkg for the payload widths.

interface psp_edge_if;
  logic                          valid;
  logic                          ready;
  logic [psp_pkg::NODE_W-1:0]    edge_from;
  logic [psp_pkg::NODE_W-1:0]    edge_to;
  logic [psp_pkg::WEIGHT_W-1:0]  edge_weight;
  logic                          edge_present;
  logic                          last_edge;
  modport source (output valid, edge_from, edge_to, edge_weight, edge_present, last_edge,
                  input ready);
  modport sink (input valid, edge_from, edge_to, edge_weight, edge_present, last_edge,
                output ready);
endinterface

interface psp_result_if;
  logic                        valid;
  logic                        ready;
  logic                        reachable;
  logic [psp_pkg::DIST_W-1:0]  even_distance;
  modport source (output valid, reachable, even_distance, input ready);
  modport sink (input valid, reachable, even_distance, output ready);
endinterface

interface psp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [psp_pkg::NODE_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/parity_state_shortest_path_unit.sv
// Top level of the parity-state shortest path unit: edge loading, search sequencer
// and result register. Depends on psp_pkg and the channel interfaces in psp_if.sv.
//
// Channel   Dir  Contents
// edge_i    in   one edge request: endpoints, weight, present flag, last flag
// cfg_i     in   node_count (target node), accepted in any cycle
// result_o  out  reachable flag and shortest even-parity distance
//
// Edges load at one request per cycle. The request flagged last starts a search
// during which edge_i is held off. The search clears the distance memory, then
// scans that memory for every settled state and once more at the end; after each
// settled state it sweeps the edge memory, checking each edge and, per relaxation,
// reading a distance and writing the shorter one. The distance memory has one read port.
// The result waits in its own register, so edge loading resumes while it stalls; a
// later search that ends before that result is taken waits for it before finishing.
module parity_state_shortest_path_unit #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  psp_edge_if.sink       edge_i,
  psp_cfg_if.sink        cfg_i,
  psp_result_if.source   result_o
);

  localparam int unsigned NW    = $clog2(MAX_NODES);
  localparam int unsigned DAW   = NW + 1;
  localparam int unsigned DEPTH = 2 * MAX_NODES;
  localparam int unsigned EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned EW    = 2 * NW + psp_pkg::WEIGHT_W;
  localparam int unsigned DW    = psp_pkg::DIST_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_SCAN_LAST, S_SETTLE, S_E_RD, S_E_CHK,
    S_R_RD, S_R_WR, S_T_RD, S_T_WAIT, S_DONE
  } state_e;

  state_e state_q;

  // Configuration register.
  logic [psp_pkg::NODE_W-1:0] node_count_q;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= psp_pkg::NODE_W'(1);
    end else if (cfg_i.valid) begin
      node_count_q <= cfg_i.data;
    end
  end

  // Edge memory: {from, to, weight}.
  logic [EW-1:0]  edge_mem [MAX_EDGES];
  logic [EW-1:0]  edge_rd_q;
  logic [ECW-1:0] edge_cnt_q;
  logic           in_acc, edge_ok;

  assign edge_i.ready = (state_q == S_IDLE);
  assign in_acc  = edge_i.valid && edge_i.ready;
  assign edge_ok = edge_i.edge_present && (17'(edge_i.edge_from) < 17'(MAX_NODES))
                   && (17'(edge_i.edge_to) < 17'(MAX_NODES))
                   && (ECW'(edge_cnt_q) < ECW'(MAX_EDGES));

  logic [ECW-1:0] e_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && edge_ok) begin
      edge_mem[edge_cnt_q[EAW-1:0]] <= {NW'(edge_i.edge_from), NW'(edge_i.edge_to),
                                        edge_i.edge_weight};
    end
    edge_rd_q <= edge_mem[e_q[EAW-1:0]];
  end

  logic [NW-1:0]                ea, eb;
  logic [psp_pkg::WEIGHT_W-1:0] ew;
  assign {ea, eb, ew} = edge_rd_q;

  // Distance memory: {settled, distance} per (node, parity) state.
  logic [DW:0]    dist_mem [DEPTH];
  logic [DW:0]    dist_rd_q;
  logic           dist_we;
  logic [DAW-1:0] dist_waddr, dist_raddr;
  logic [DW:0]    dist_wdata;

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rd_q <= dist_mem[dist_raddr];
  end

  // Search registers.
  logic [DAW-1:0] idx_q, prev_q, best_q, tgt_q;
  logic           scan_vld_q, pend_b_q;
  logic [DW-1:0]  bd_q;
  logic           out_valid_q;
  logic [DW-1:0]  out_dist_q;

  logic [16:0]    target_ext;
  logic [DW:0]    sum;
  logic [DW-1:0]  nd;
  logic [NW-1:0]  cur_u;
  logic           cur_p;

  assign target_ext = 17'(node_count_q);
  assign cur_u      = best_q[DAW-1:1];
  assign cur_p      = best_q[0];
  assign sum        = {1'b0, bd_q} + (DW+1)'(ew);
  assign nd         = (sum > (DW+1)'(psp_pkg::DIST_SAT)) ? psp_pkg::DIST_SAT : sum[DW-1:0];

  // Memory control follows the sequencer state.
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = idx_q;
    dist_wdata = {1'b0, psp_pkg::DIST_INF};
    dist_raddr = idx_q;
    unique case (state_q)
      S_CLEAR: begin
        dist_we = 1'b1;
        // Node one at even parity is the start and begins at distance zero.
        if (idx_q == DAW'(2)) dist_wdata = '0;
      end
      S_SETTLE: begin
        dist_we    = (bd_q != psp_pkg::DIST_INF);
        dist_waddr = best_q;
        dist_wdata = {1'b1, bd_q};
      end
      S_R_RD: dist_raddr = tgt_q;
      S_R_WR: begin
        dist_we    = (nd < dist_rd_q[DW-1:0]);
        dist_waddr = tgt_q;
        dist_wdata = {dist_rd_q[DW], nd};
      end
      S_T_RD: dist_raddr = {target_ext[NW-1:0], 1'b0};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      edge_cnt_q  <= '0;
      e_q         <= '0;
      idx_q       <= '0;
      prev_q      <= '0;
      best_q      <= '0;
      tgt_q       <= '0;
      scan_vld_q  <= 1'b0;
      pend_b_q    <= 1'b0;
      bd_q        <= psp_pkg::DIST_INF;
      out_valid_q <= 1'b0;
      out_dist_q  <= psp_pkg::DIST_INF;
    end else begin
      // The result register fills when a search finishes and empties when taken.
      if (state_q == S_DONE)     out_valid_q <= 1'b1;
      else if (result_o.ready)   out_valid_q <= 1'b0;

      // Minimum search over the values read during the scan.
      if ((state_q == S_SCAN || state_q == S_SCAN_LAST) && scan_vld_q
          && !dist_rd_q[DW] && (dist_rd_q[DW-1:0] < bd_q)) begin
        bd_q   <= dist_rd_q[DW-1:0];
        best_q <= prev_q;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (edge_ok) edge_cnt_q <= edge_cnt_q + ECW'(1);
            if (edge_i.last_edge) begin
              idx_q   <= '0;
              state_q <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          idx_q <= idx_q + DAW'(1);
          if (idx_q == DAW'(DEPTH - 1)) begin
            idx_q      <= '0;
            bd_q       <= psp_pkg::DIST_INF;
            scan_vld_q <= 1'b0;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          prev_q     <= idx_q;
          scan_vld_q <= 1'b1;
          idx_q      <= idx_q + DAW'(1);
          if (idx_q == DAW'(DEPTH - 1)) state_q <= S_SCAN_LAST;
        end
        S_SCAN_LAST: state_q <= S_SETTLE;
        S_SETTLE: begin
          e_q <= '0;
          if (bd_q == psp_pkg::DIST_INF) state_q <= S_T_RD;
          else                           state_q <= S_E_RD;
        end
        S_E_RD: begin
          if (e_q == edge_cnt_q) begin
            idx_q      <= '0;
            bd_q       <= psp_pkg::DIST_INF;
            scan_vld_q <= 1'b0;
            state_q    <= S_SCAN;
          end else begin
            state_q <= S_E_CHK;
          end
        end
        S_E_CHK: begin
          priority if (ea == cur_u) begin
            tgt_q    <= {eb, ~cur_p};
            pend_b_q <= (eb == cur_u);
            state_q  <= S_R_RD;
          end else if (eb == cur_u) begin
            tgt_q    <= {ea, ~cur_p};
            pend_b_q <= 1'b0;
            state_q  <= S_R_RD;
          end else begin
            e_q     <= e_q + ECW'(1);
            state_q <= S_E_RD;
          end
        end
        S_R_RD: state_q <= S_R_WR;
        S_R_WR: begin
          if (pend_b_q) begin
            tgt_q    <= {ea, ~cur_p};
            pend_b_q <= 1'b0;
            state_q  <= S_R_RD;
          end else begin
            e_q     <= e_q + ECW'(1);
            state_q <= S_E_RD;
          end
        end
        S_T_RD: begin
          // A result still waiting in the output register holds the search here,
          // so its distance is not overwritten.
          if (!out_valid_q || result_o.ready) begin
            if (target_ext >= 17'(MAX_NODES)) begin
              out_dist_q <= psp_pkg::DIST_INF;
              state_q    <= S_DONE;
            end else begin
              state_q <= S_T_WAIT;
            end
          end
        end
        S_T_WAIT: begin
          out_dist_q <= dist_rd_q[DW-1:0];
          state_q    <= S_DONE;
        end
        S_DONE: begin
          edge_cnt_q <= '0;
          state_q    <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.even_distance = out_dist_q;
  assign result_o.reachable     = (out_dist_q != psp_pkg::DIST_INF);

endmodule

>>> rtl/psp_checker.sv
// Port-level checks for the parity-state shortest path unit, bound to the top level.
// Depends on psp_pkg and the port names of parity_state_shortest_path_unit.
module psp_port_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic                       res_reachable_i,
  input logic [psp_pkg::DIST_W-1:0] res_dist_i
);

  // The reachable flag agrees with the distance it travels with.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_reachable_i == (res_dist_i != psp_pkg::DIST_INF)))
    else $error("reachable flag disagrees with distance");

  // A request that ends a graph holds off the edge channel for the search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i)
    else $error("edge channel open during search");

  // A new result appears only at the end of a search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> !$past(in_ready_i))
    else $error("result without a search");

  // A stalled result is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(res_dist_i)))
    else $error("stalled result dropped or changed");

endmodule

bind parity_state_shortest_path_unit psp_port_checker u_psp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (edge_i.valid),
  .in_ready_i      (edge_i.ready),
  .in_last_i       (edge_i.last_edge),
  .res_valid_i     (result_o.valid),
  .res_ready_i     (result_o.ready),
  .res_reachable_i (result_o.reachable),
  .res_dist_i      (result_o.even_distance)
);
